// ===== rtl/pfr_pkg.sv =====
// pfr_pkg: shared types and constants of the ps/2 frame receiver
// no dependencies; used by the interfaces and every rtl module
package pfr_pkg;

  localparam int QUEUE_SLOTS = 64;

  localparam int          TIME_W      = 32;
  localparam int          CNT_W       = 4;
  localparam int          BYTE_W      = 8;
  localparam logic [CNT_W-1:0] FRAME_BITS    = 4'd11;
  localparam logic [CNT_W-1:0] LAST_DATA_POS = 4'd7;
  localparam logic [TIME_W-1:0] GAP_TIMEOUT_RST = 32'd250;

  // input event codes
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_kind_t;

  // word passed from the frame assembler to the byte queue
  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] data;
  } op_t;

endpackage

// ===== rtl/pfr_ifs.sv =====
// pfr_ifs: valid/ready channel interfaces of the ps/2 frame receiver
// depends on pfr_pkg for field widths
interface pfr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic                        data_bit;
  logic [pfr_pkg::TIME_W-1:0]  edge_time;
  modport source (output valid, func, data_bit, edge_time, input ready);
  modport sink   (input valid, func, data_bit, edge_time, output ready);
endinterface

interface pfr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        code_valid;
  logic [pfr_pkg::BYTE_W-1:0]  scan_byte;
  modport source (output valid, code_valid, scan_byte, input ready);
  modport sink   (input valid, code_valid, scan_byte, output ready);
endinterface

interface pfr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pfr_pkg::TIME_W-1:0]  gap_timeout;
  modport source (output valid, gap_timeout, input ready);
  modport sink   (input valid, gap_timeout, output ready);
endinterface

// ===== rtl/pfr_front.sv =====
// pfr_front: frame assembler, takes edge and read events, emits queue ops
// depends on pfr_pkg and pfr_ifs
module pfr_front (
  input  logic              clk,
  input  logic              rst_n,
  pfr_in_if.sink            in_ch,
  pfr_cfg_if.sink           cfg_ch,
  output logic              op_valid,
  input  logic              op_ready,
  output pfr_pkg::op_t      op_data
);

  logic [pfr_pkg::CNT_W-1:0]  cnt_r;
  logic [pfr_pkg::CNT_W-1:0]  cnt_nxt;
  logic [pfr_pkg::BYTE_W-1:0] shift_r;
  logic [pfr_pkg::BYTE_W-1:0] shift_nxt;
  logic [pfr_pkg::TIME_W-1:0] last_r;
  logic [pfr_pkg::TIME_W-1:0] gap_r;

  logic                       in_fire;
  logic                       edge_fire;
  logic [pfr_pkg::TIME_W-1:0] gap;
  logic                       stale;
  logic [pfr_pkg::CNT_W-1:0]  cnt_eff;
  logic [pfr_pkg::CNT_W-1:0]  pos;
  logic [pfr_pkg::BYTE_W-1:0] shift_eff;
  logic [pfr_pkg::BYTE_W-1:0] shift_new;
  logic                       frame_done;

  assign in_ch.ready  = op_ready;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign edge_fire    = in_fire && (in_ch.func == pfr_pkg::FUNC_EDGE);

  always_comb begin
    gap       = in_ch.edge_time - last_r;
    stale     = gap > gap_r;
    cnt_eff   = stale ? '0 : cnt_r;
    shift_eff = stale ? '0 : shift_r;
    pos       = cnt_eff - 4'd1;
    shift_new = shift_eff;
    // data bits sit at frame positions one to eight
    if (pos <= pfr_pkg::LAST_DATA_POS) begin
      shift_new[pos[2:0]] = in_ch.data_bit;
    end
    frame_done = (cnt_eff == pfr_pkg::FRAME_BITS - 4'd1);
    if (frame_done) begin
      cnt_nxt   = '0;
      shift_nxt = '0;
    end else begin
      cnt_nxt   = cnt_eff + 4'd1;
      shift_nxt = shift_new;
    end
  end

  assign op_valid     = in_fire && ((in_ch.func == pfr_pkg::FUNC_READ) || frame_done);
  assign op_data.kind = (in_ch.func == pfr_pkg::FUNC_READ) ? pfr_pkg::OP_READ
                                                          : pfr_pkg::OP_PUSH;
  assign op_data.data = shift_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      shift_r <= '0;
      last_r  <= '0;
      gap_r   <= pfr_pkg::GAP_TIMEOUT_RST;
    end else begin
      if (edge_fire) begin
        cnt_r   <= cnt_nxt;
        shift_r <= shift_nxt;
        last_r  <= in_ch.edge_time;
      end
      if (cfg_ch.valid) begin
        gap_r <= cfg_ch.gap_timeout;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < pfr_pkg::FRAME_BITS)
    else $error("bit counter out of frame range");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    edge_fire && frame_done |=> cnt_r == '0 && shift_r == '0)
    else $error("completed frame not cleared");

  a_edge_time: assert property (@(posedge clk) disable iff (!rst_n)
    edge_fire |=> last_r == $past(in_ch.edge_time))
    else $error("edge time not recorded");

endmodule

// ===== rtl/pfr_opq.sv =====
// pfr_opq: two-entry op queue between frame assembler and byte queue
// depends on pfr_pkg
module pfr_opq (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  pfr_pkg::op_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output pfr_pkg::op_t out_data
);

  pfr_pkg::op_t slot_r [2];
  logic         wr_r;
  logic         rd_r;
  logic [1:0]   cnt_r;
  logic         push;
  logic         pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[rd_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("op queue overflow");

  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) == (wr_r != rd_r))
    else $error("op queue pointers disagree with count");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !pop |=> cnt_r == 2'd2)
    else $error("op queue count lost while full");

endmodule

// ===== rtl/pfr_back.sv =====
// pfr_back: ring byte queue with registered read and result register
// depends on pfr_pkg and pfr_ifs
module pfr_back #(
  parameter int QUEUE_SLOTS = pfr_pkg::QUEUE_SLOTS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         op_valid,
  output logic         op_ready,
  input  pfr_pkg::op_t op_data,
  pfr_out_if.source    out_ch
);

  localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SLOTS - 1);

  logic [pfr_pkg::BYTE_W-1:0] mem [QUEUE_SLOTS];
  logic [IDX_W-1:0]           wr_idx_r;
  logic [IDX_W-1:0]           rd_idx_r;
  logic [IDX_W-1:0]           wr_idx_nxt;
  logic [IDX_W-1:0]           rd_idx_nxt;
  logic                       pend_r;
  logic                       code_r;
  logic [pfr_pkg::BYTE_W-1:0] rd_data_r;

  logic is_read;
  logic fire;
  logic push_fire;
  logic rd_fire;
  logic full;
  logic empty;

  assign is_read    = (op_data.kind == pfr_pkg::OP_READ);
  // pushes never wait on the result register
  assign op_ready   = !is_read || !pend_r || out_ch.ready;
  assign fire       = op_valid && op_ready;
  assign push_fire  = fire && !is_read;
  assign rd_fire    = fire && is_read;
  assign wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
  assign rd_idx_nxt = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
  assign full       = (wr_idx_nxt == rd_idx_r);
  assign empty      = (wr_idx_r == rd_idx_r);

  assign out_ch.valid      = pend_r;
  assign out_ch.code_valid = code_r;
  assign out_ch.scan_byte  = code_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (push_fire && !full) begin
      mem[wr_idx_r] <= op_data.data;
    end
    if (rd_fire) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
      code_r   <= 1'b0;
    end else begin
      if (push_fire && !full) begin
        wr_idx_r <= wr_idx_nxt;
      end
      if (rd_fire) begin
        pend_r <= 1'b1;
        code_r <= !empty;
        if (!empty) rd_idx_r <= rd_idx_nxt;
      end else if (out_ch.ready) begin
        pend_r <= 1'b0;
      end
    end
  end

  a_push_adv: assert property (@(posedge clk) disable iff (!rst_n)
    push_fire && !full |=> wr_idx_r != $past(wr_idx_r))
    else $error("accepted byte did not advance write index");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push_fire && full |=> wr_idx_r == $past(wr_idx_r))
    else $error("byte written into a full queue");

  a_read_code: assert property (@(posedge clk) disable iff (!rst_n)
    rd_fire |=> pend_r && code_r == $past(!empty))
    else $error("read result does not match queue state");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r <= LAST_IDX && rd_idx_r <= LAST_IDX)
    else $error("queue index out of range");

endmodule

// ===== rtl/ps2_frame_receiver_fifo_core.sv =====
// ps2_frame_receiver_fifo_core: top level of the ps/2 frame receiver
// depends on pfr_pkg, pfr_ifs, pfr_front, pfr_opq and pfr_back

// PS/2 device-to-host receiver with a byte queue. Each input word is either
// a falling clock edge (func 0, with the data line level and a free-running
// timestamp) or a read request (func 1). An edge more than gap_timeout ticks
// after the previous one (mod 2^32) drops any partial frame first; the
// eleventh bit of a frame pushes the eight data bits into a ring queue of
// QUEUE_SLOTS entries holding at most QUEUE_SLOTS-1 bytes, a byte that finds
// the queue full is dropped. Start, parity and stop bits are not checked.
// A read returns one result word: code_valid 1 with the oldest byte, or
// code_valid 0 and scan_byte 0 when the queue is empty; edges return nothing.
// One input word is accepted every clock cycle while result words are taken.
// A read accepted at the input passes through the two-entry op queue and then
// the registered read port of the byte memory before its result word is
// offered. While a result word waits, later reads hold in the op queue and
// the input stalls once that queue holds two words. No clearing pass follows
// reset.
// gap_timeout resets to 250; the user must write it only while the block is idle (unchecked).
module ps2_frame_receiver_fifo_core #(
  parameter int QUEUE_SLOTS = pfr_pkg::QUEUE_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  pfr_in_if.sink     in_ch,
  pfr_out_if.source  out_ch,
  pfr_cfg_if.sink    cfg_ch
);

  // front to op queue
  logic         fq_valid;
  logic         fq_ready;
  pfr_pkg::op_t fq_data;

  // op queue to back
  logic         qb_valid;
  logic         qb_ready;
  pfr_pkg::op_t qb_data;

  // frame assembly and the gap timeout register
  pfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .op_valid (fq_valid),
    .op_ready (fq_ready),
    .op_data  (fq_data)
  );

  // decouples the assembler from result stalls, keeps ops in order
  pfr_opq u_opq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  // ring byte queue and result register
  pfr_back #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (qb_valid),
    .op_ready (qb_ready),
    .op_data  (qb_data),
    .out_ch   (out_ch)
  );

  // empty reads always report a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.code_valid |-> out_ch.scan_byte == '0)
    else $error("empty read carries a nonzero byte");

  // an op leaving the front is always taken by the op queue
  a_front_taken: assert property (@(posedge clk) disable iff (!rst_n)
    fq_valid |-> fq_ready)
    else $error("front op lost");

  // a result stays put while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.scan_byte))
    else $error("stalled result changed");

endmodule

// ===== test/tb_ps2_frame_receiver_fifo_core.sv =====
// tb_ps2_frame_receiver_fifo_core: self-checking testbench of the ps/2 frame receiver
// drives edge and read words, predicts every read reply and checks the result words
// depends on pfr_pkg, pfr_ifs and the rtl of ps2_frame_receiver_fifo_core
module tb_ps2_frame_receiver_fifo_core;

  localparam int LIMIT_CYCLES = 400000;
  localparam int IDLE_SETTLE  = 10;
  localparam logic [pfr_pkg::TIME_W-1:0] GAP_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic                       func;
    logic                       data_bit;
    logic [pfr_pkg::TIME_W-1:0] edge_time;
  } ps2_word_t;

  typedef struct {
    logic                       code_valid;
    logic [pfr_pkg::BYTE_W-1:0] scan_byte;
  } read_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  pfr_in_if  in_if ();
  pfr_out_if out_if ();
  pfr_cfg_if cfg_if ();

  ps2_frame_receiver_fifo_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // words waiting to be driven, and replies the block still owes us
  ps2_word_t   ps2_words_q[$];
  read_reply_t read_replies_q[$];

  // predicted receiver state
  logic [pfr_pkg::TIME_W-1:0] rx_gap_limit = pfr_pkg::GAP_TIMEOUT_RST;
  logic [pfr_pkg::CNT_W-1:0]  rx_bits      = '0;
  logic [pfr_pkg::BYTE_W-1:0] rx_shift     = '0;
  logic [pfr_pkg::TIME_W-1:0] rx_last_time = '0;
  logic [pfr_pkg::BYTE_W-1:0] ring_bytes [pfr_pkg::QUEUE_SLOTS];
  int                         ring_wr      = 0;
  int                         ring_rd      = 0;

  // stimulus side bookkeeping
  logic [pfr_pkg::TIME_W-1:0] stim_tick = '0;
  logic [pfr_pkg::TIME_W-1:0] stim_gap  = pfr_pkg::GAP_TIMEOUT_RST;

  // driver / receiver handshake state
  bit        word_busy    = 1'b0;
  bit        word_taken   = 1'b0;
  ps2_word_t drv_word;
  int        burst_left   = 0;
  int        idle_left    = 0;
  int        rx_hold_left = 0;
  int        rx_mode      = 0;
  int        rx_cycle     = 0;

  int          err_count   = 0;
  int          cycle_count = 0;
  read_reply_t want_reply;

  // one accepted word through the receiver; a read leaves its reply in the queue
  function automatic void predict_word(input logic func, input logic bit_in,
                                       input logic [pfr_pkg::TIME_W-1:0] t);
    logic [pfr_pkg::TIME_W-1:0] gap_ticks;
    logic [pfr_pkg::CNT_W-1:0]  pos;
    read_reply_t                r;
    int                         nxt;
    if (func == pfr_pkg::FUNC_EDGE) begin
      // distance wraps mod 2^32, so an earlier stamp is a long gap
      gap_ticks = t - rx_last_time;
      if (gap_ticks > rx_gap_limit) begin
        rx_bits  = '0;
        rx_shift = '0;
      end
      rx_last_time = t;
      // frame positions 1..8 carry the data, lsb first
      pos = rx_bits - 4'd1;
      if (pos <= pfr_pkg::LAST_DATA_POS) rx_shift[pos[2:0]] = rx_shift[pos[2:0]] | bit_in;
      rx_bits = rx_bits + 4'd1;
      if (rx_bits == pfr_pkg::FRAME_BITS) begin
        // one slot stays free, a byte that finds the ring full is lost
        nxt = (ring_wr + 1) % pfr_pkg::QUEUE_SLOTS;
        if (nxt != ring_rd) begin
          ring_bytes[ring_wr] = rx_shift;
          ring_wr = nxt;
        end
        rx_bits  = '0;
        rx_shift = '0;
      end
    end else begin
      if (ring_rd == ring_wr) begin
        r = '{1'b0, 8'h00};
      end else begin
        r = '{1'b1, ring_bytes[ring_rd]};
        ring_rd = (ring_rd + 1) % pfr_pkg::QUEUE_SLOTS;
      end
      read_replies_q.push_back(r);
    end
  endfunction

  // spacing between consecutive edges of one frame, never beyond the timeout
  function automatic logic [pfr_pkg::TIME_W-1:0] frame_step();
    logic [pfr_pkg::TIME_W-1:0] step;
    case ($urandom_range(0, 7))
      0: begin
        step = stim_gap;
      end
      1: begin
        step = '0;
      end
      default: begin
        if (stim_gap <= 5000 || $urandom_range(0, 3) == 0) step = $urandom_range(0, stim_gap);
        else step = $urandom_range(0, 5000);
      end
    endcase
    return step;
  endfunction

  function automatic void add_edge(input logic b, input logic [pfr_pkg::TIME_W-1:0] dt);
    stim_tick = stim_tick + dt;
    ps2_words_q.push_back('{pfr_pkg::FUNC_EDGE, b, stim_tick});
  endfunction

  // fields of a read are don't-care, so they get random noise
  function automatic void add_read();
    ps2_words_q.push_back('{pfr_pkg::FUNC_READ, 1'($urandom), $urandom});
  endfunction

  // ctl holds start, parity and stop; exact spaces every later edge at the timeout
  function automatic void add_frame(input logic [pfr_pkg::BYTE_W-1:0] dbyte,
                                    input logic [2:0] ctl,
                                    input logic [pfr_pkg::TIME_W-1:0] lead,
                                    input bit exact);
    add_edge(ctl[2], lead);
    for (int i = 0; i < pfr_pkg::BYTE_W; i++) begin
      add_edge(dbyte[i], exact ? stim_gap : frame_step());
    end
    add_edge(ctl[1], exact ? stim_gap : frame_step());
    add_edge(ctl[0], exact ? stim_gap : frame_step());
  endfunction

  // mostly well-formed frames, mixed with reads, torn frames and stray edges
  task automatic gen_mixed(input int n);
    int                         made;
    int                         sel;
    int                         k;
    logic [pfr_pkg::TIME_W-1:0] lead;
    made = 0;
    while (made < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        // half the frames open after a real gap so they resync, when the timeout leaves room for one
        if (sel < 30 && stim_gap < 32'hFFFF_0000) lead = stim_gap + 1 + $urandom_range(0, 1000);
        else lead = frame_step();
        add_frame(8'($urandom), 3'($urandom), lead, 1'b0);
        made += 11;
      end else if (sel < 80) begin
        k = $urandom_range(1, 4);
        repeat (k) add_read();
        made += k;
      end else if (sel < 90) begin
        k = $urandom_range(1, 10);
        repeat (k) add_edge(1'($urandom), frame_step());
        made += k;
      end else begin
        add_edge(1'($urandom), $urandom);
        made++;
      end
    end
  endtask

  // block is idle once every word is in, every reply is out and the pipe settled
  task automatic wait_idle();
    while (ps2_words_q.size() != 0 || word_busy || read_replies_q.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_gap_timeout(input logic [pfr_pkg::TIME_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.gap_timeout <= v;
    stim_gap = v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // sender: bursts of random length with idle gaps, now and then a long unbroken run
  always @(negedge clk) begin
    if (word_taken) begin
      word_taken = 1'b0;
      word_busy  = 1'b0;
    end
    if (!word_busy) begin
      if (idle_left > 0) begin
        idle_left--;
        in_if.valid <= 1'b0;
      end else if (ps2_words_q.size() > 0) begin
        drv_word = ps2_words_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.func      <= drv_word.func;
        in_if.data_bit  <= drv_word.data_bit;
        in_if.edge_time <= drv_word.edge_time;
        word_busy = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = 200;
          idle_left  = 0;
        end else begin
          burst_left = $urandom_range(0, 12);
          idle_left  = $urandom_range(0, 6);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches every so often; a hold-off overrides it
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: begin
          out_if.ready <= 1'b1;
        end
        1: begin
          out_if.ready <= 1'($urandom);
        end
        2: begin
          out_if.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_if.ready <= (rx_cycle % 5 != 0);
        end
      endcase
    end
  end

  // monitor: config and input words feed the predictor, result words get checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) rx_gap_limit = cfg_if.gap_timeout;
      if (in_if.valid && in_if.ready) begin
        predict_word(in_if.func, in_if.data_bit, in_if.edge_time);
        word_taken = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        if (read_replies_q.size() == 0) begin
          $error("result word with no read pending: code_valid %0d scan_byte 0x%02h",
                 out_if.code_valid, out_if.scan_byte);
          err_count++;
        end else begin
          want_reply = read_replies_q.pop_front();
          if (out_if.code_valid !== want_reply.code_valid) begin
            $error("code_valid mismatch: expected %0d, actual %0d",
                   want_reply.code_valid, out_if.code_valid);
            err_count++;
          end
          if (out_if.scan_byte !== want_reply.scan_byte) begin
            $error("scan_byte mismatch: expected 0x%02h, actual 0x%02h",
                   want_reply.scan_byte, out_if.scan_byte);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("ps2_frame_receiver_fifo_core verification failed");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.func         = pfr_pkg::FUNC_EDGE;
    in_if.data_bit     = 1'b0;
    in_if.edge_time    = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.gap_timeout = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed, default timeout: empty read with all-ones noise fields
    ps2_words_q.push_back('{pfr_pkg::FUNC_READ, 1'b1, 32'hFFFF_FFFF});
    // partial frame, spacing one tick under the timeout, then a forward wrap to zero
    stim_tick = 32'hFFFF_FF06;
    ps2_words_q.push_back('{pfr_pkg::FUNC_EDGE, 1'b1, stim_tick});
    add_edge(1'b0, stim_gap - 1);
    add_edge(1'b1, 32'd1);
    // an earlier stamp is a huge gap: the partial frame goes away
    add_frame(8'hFF, 3'b011, 32'hFFFF_FF80, 1'b1);
    add_read();
    // framing bits inverted, they must not matter
    add_frame(8'h00, 3'b100, 32'd1, 1'b1);
    add_read();
    add_read();

    // fill the ring past capacity with any spacing, then pile up reads
    // behind a long receiver hold-off so the input backs up
    write_gap_timeout(GAP_MAX);
    stim_tick = $urandom;
    repeat (pfr_pkg::QUEUE_SLOTS + 2) begin
      add_frame(8'($urandom), 3'($urandom), frame_step(), 1'b0);
    end
    wait_idle();
    rx_hold_left = 400;
    repeat (pfr_pkg::QUEUE_SLOTS + 6) add_read();

    // random phases over a spread of timeouts, extremes included
    write_gap_timeout('0);
    stim_tick = $urandom;
    gen_mixed(150);
    write_gap_timeout($urandom_range(1, 1000));
    stim_tick = $urandom;
    gen_mixed(150);
    write_gap_timeout($urandom);
    stim_tick = $urandom;
    gen_mixed(150);
    write_gap_timeout(pfr_pkg::GAP_TIMEOUT_RST);
    stim_tick = $urandom;
    gen_mixed(150);
    write_gap_timeout(GAP_MAX);
    stim_tick = $urandom;
    gen_mixed(150);
    write_gap_timeout(32'd1);
    stim_tick = $urandom;
    gen_mixed(150);

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0 && read_replies_q.size() == 0) begin
      $display("ps2_frame_receiver_fifo_core verification clean");
    end else begin
      $display("ps2_frame_receiver_fifo_core verification failed");
    end
    $finish;
  end

endmodule

// ===== ps2_frame_receiver_fifo_core.f =====
rtl/pfr_pkg.sv
rtl/pfr_ifs.sv
rtl/pfr_front.sv
rtl/pfr_opq.sv
rtl/pfr_back.sv
rtl/ps2_frame_receiver_fifo_core.sv
test/tb_ps2_frame_receiver_fifo_core.sv
